// File: sv/sorted_list_engine_unit_assert.svh
// assertion macros for the sorted list engine checker
// no dependencies; included by the checker file
`ifndef SORTED_LIST_ENGINE_UNIT_ASSERT_SVH
`define SORTED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sle_pkg.sv
// shared types and constants for the sorted list engine
// no dependencies; imported by every module of the block
package sle_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 4;
   localparam int COUNT_W      = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] position;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } state_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic                      cmp_en;
      logic                      ins_en;
      logic                      rem_en;
      logic signed [VALUE_W-1:0] key;
   } cell_ctl_type;

endpackage

// File: sv/sorted_list_engine_unit.sv
// sorted list engine: top level with control sequencer and cell chain
// depends on sle_pkg and sle_cell
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells. Each item (cmd, value) is accepted when start is high and busy is
// low; busy then stays high through the compare and execute states, and one
// result appears on rsp_payload with rsp_valid high for exactly one cycle,
// from registers loaded in the execute state. The receiver cannot stall it,
// so it must take the result in that cycle. A new item may be started in the
// cycle the result is shown, but none is taken while one is in progress. The
// sequencer steps are: every cell compares its entry with the key, then the
// boundary cell is located and the chain shifts, then the registered result
// is presented. Insert puts the value before the first entry greater than
// or equal to it and fails on a full list; find and remove act on the first
// equal entry. position is 0 whenever ok is 0 and carries the low 4 bits of
// the index; entry_count the low 5 bits of the count. Unused command code 3
// gives ok 0 and changes nothing. No clearing pass is needed after reset;
// entries above the count are never looked at.
module sorted_list_engine_unit
   import sle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   // captured item
   logic [1:0]                cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;

   // entry count
   logic [CNT_W-1:0] count_ff, count_in;

   // registered result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   cell_ctl_type ctl;

   // chain wiring
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_lt;
   logic [CAPACITY-1:0]       cell_eq;
   logic [CAPACITY-1:0]       cell_bnd;
   logic [CAPACITY-1:0]       cell_active;

   // decode of the boundary cell
   logic             found;
   logic [POS_W-1:0] bnd_pos;
   logic             full;

   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      found   = 1'b0;
      bnd_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found   = found | (cell_bnd[i] & cell_eq[i]);
         bnd_pos = bnd_pos | (cell_bnd[i] ? POS_W'(i) : '0);
      end
   end

   // the cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                      left_lt;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      assign cell_active[g] = (CNT_W'(g) < count_ff);

      if (g == 0) begin : g_first
         // cell 0 always sees a smaller left neighbor
         assign left_lt    = 1'b1;
         assign left_value = ctl.key;
      end else begin : g_mid
         assign left_lt    = cell_lt[g-1];
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_value = cell_value[g+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .active      (cell_active[g]),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .value_ff    (cell_value[g]),
         .lt_ff       (cell_lt[g]),
         .eq_ff       (cell_eq[g]),
         .bnd         (cell_bnd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   // sequencer: next state, chain control and result
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl.cmp_en   = 1'b0;
      ctl.ins_en   = 1'b0;
      ctl.rem_en   = 1'b0;
      ctl.key      = key_ff;
      busy         = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_payload.cmd;
               key_in   = req_payload.value;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // every cell compares its entry against the key
            ctl.cmp_en = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_valid_in    = 1'b1;
            rsp_in.ok       = 1'b0;
            rsp_in.position = '0;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (!full) begin
                     ctl.ins_en      = 1'b1;
                     count_in        = count_ff + 1'b1;
                     rsp_in.ok       = 1'b1;
                     rsp_in.position = bnd_pos;
                  end
               end
               CMD_FIND: begin
                  if (found) begin
                     rsp_in.ok       = 1'b1;
                     rsp_in.position = bnd_pos;
                  end
               end
               CMD_REMOVE: begin
                  if (found) begin
                     ctl.rem_en      = 1'b1;
                     count_in        = count_ff - 1'b1;
                     rsp_in.ok       = 1'b1;
                     rsp_in.position = bnd_pos;
                  end
               end
               default: begin
                  // unused code: nothing changes
               end
            endcase
            rsp_in.entry_count = COUNT_W'(count_in);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: sv/sle_cell.sv
// one storage cell of the sorted list chain
// depends on sle_pkg for the control struct and widths
module sle_cell
   import sle_pkg::*;
(
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic                      active,
   input  logic                      left_lt,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic signed [VALUE_W-1:0] value_ff,
   output logic                      lt_ff,
   output logic                      eq_ff,
   output logic                      bnd
);

   logic signed [VALUE_W-1:0] value_in;
   logic                      lt_in;
   logic                      eq_in;

   // first cell at or above the key
   assign bnd = left_lt && !lt_ff;

   always_comb begin
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = active && (value_ff < ctl.key);
         eq_in = active && (value_ff == ctl.key);
      end
      if (ctl.ins_en && !lt_ff) begin
         value_in = left_lt ? ctl.key : left_value;
      end else if (ctl.rem_en && !lt_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

endmodule

// File: sv/sle_checker.sv
// port-level checker for the sorted list engine, bound to the top level
// depends on sle_pkg and sorted_list_engine_unit_assert.svh
`include "sorted_list_engine_unit_assert.svh"

module sle_checker
   import sle_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   // a result only follows a busy cycle
   `SLE_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "result without busy")
   // strobe is a single pulse
   `SLE_ASSERT_NXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   // a failed item reports index zero
   `SLE_ASSERT_IMP(a_fail_pos, clock, reset, rsp_valid && !rsp_payload.ok,
                   rsp_payload.position == '0, "failed item with nonzero position")
   // an accepted item keeps the block busy
   `SLE_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "accept without busy")

endmodule

bind sorted_list_engine_unit sle_checker u_sle_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for sorted_list_engine_unit, the ascending signed value list
// depends on sle_pkg and the block's rtl; a sorted-list predictor checks every result
module testbench;
   import sle_pkg::*;

   localparam int         LIST_CAP     = DEF_CAPACITY;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 725;
   // no idling once this few items are left to send
   localparam int         QUIET_TAIL   = 80;
   // cycles to wait after the last result
   localparam int         DRAIN_CYCLES = 10;

   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_type;

   // dut connections, all inputs known from time zero
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   sorted_list_engine_unit uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the list: only the first list_len slots are meaningful
   logic signed [VALUE_W-1:0] list_vals [LIST_CAP];
   int                        list_len = 0;

   req_type pending_items [$];
   rsp_type expected_results [$];
   // values recently inserted, so that finds and removes hit often
   logic signed [VALUE_W-1:0] recent_values [$];

   // run statistics, indexed by command code
   int hit_count  [4] = '{default: 0};
   int miss_count [4] = '{default: 0};
   int peak_count     = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int gap_left       = 0;
   rsp_type expected_now;

   // applies one command to the predicted list and returns the result it should give
   function automatic rsp_type apply_list_command(req_type item);
      rsp_type                   res;
      logic signed [VALUE_W-1:0] key;
      int                        idx;
      res = '0;
      key = item.value;
      idx = 0;
      case (item.cmd)
         CMD_INSERT: begin
            if (list_len < LIST_CAP) begin
               // goes in front of the first entry >= key, so ahead of equal ones
               while (idx < list_len && list_vals[idx] < key)
                  idx++;
               for (int k = list_len; k > idx; k--)
                  list_vals[k] = list_vals[k-1];
               list_vals[idx] = key;
               list_len++;
               res.ok       = 1'b1;
               res.position = idx[POS_W-1:0];
            end
         end
         CMD_FIND, CMD_REMOVE: begin
            // lowest-index equal entry
            while (idx < list_len && list_vals[idx] != key)
               idx++;
            if (idx < list_len) begin
               res.ok       = 1'b1;
               res.position = idx[POS_W-1:0];
               if (item.cmd == CMD_REMOVE) begin
                  for (int k = idx; k + 1 < list_len; k++)
                     list_vals[k] = list_vals[k+1];
                  list_len--;
               end
            end
         end
         default: ;
      endcase
      if (res.ok)
         hit_count[item.cmd]++;
      else
         miss_count[item.cmd]++;
      if (list_len > peak_count)
         peak_count = list_len;
      res.entry_count = list_len[COUNT_W-1:0];
      return res;
   endfunction

   function automatic void queue_item(logic [1:0] cmd, logic signed [VALUE_W-1:0] value);
      req_type item;
      item.cmd   = cmd;
      item.value = value;
      pending_items.push_back(item);
      if (cmd == CMD_INSERT) begin
         recent_values.push_back(value);
         if (recent_values.size() > 32)
            void'(recent_values.pop_front());
      end
   endfunction

   // mostly a narrow band around zero so duplicates and matches are common
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return int'($urandom_range(0, 8)) - 4;
         4, 5: begin
            if (recent_values.size() != 0)
               return recent_values[$urandom_range(0, recent_values.size() - 1)];
            else
               return $urandom;
         end
         6: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h8000_0001;
               2: return 32'h7fff_ffff;
               3: return 32'h7fff_fffe;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // driver: an item is taken at an edge with start high and busy low;
   // start stays up, with the same item, while busy holds it off
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(apply_list_command(req_payload));
            items_accepted++;
         end
         if (start && busy) begin
            // item still waiting, leave it in place
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else if (pending_items.size() > QUIET_TAIL && (items_accepted % 120) >= 40 &&
                      $urandom_range(0, 5) == 0) begin
            // idle burst, this one included, of random length set through gap_left
            gap_left = $urandom_range(1, 11) - 1;
            start <= 1'b0;
         end else begin
            req_payload <= pending_items.pop_front();
            start       <= 1'b1;
         end
      end
   end

   // monitor: a result is shown for one cycle only, so every strobe is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding: expected none, actual ok %0b position %0d count %0d",
                        $time, rsp_payload.ok, rsp_payload.position, rsp_payload.entry_count);
               mismatch_count++;
            end else begin
               expected_now = expected_results.pop_front();
               results_seen++;
               if (rsp_payload.ok !== expected_now.ok) begin
                  $display("%0t: ok mismatch: expected %0b actual %0b",
                           $time, expected_now.ok, rsp_payload.ok);
                  mismatch_count++;
               end
               if (rsp_payload.position !== expected_now.position) begin
                  $display("%0t: position mismatch: expected %0d actual %0d",
                           $time, expected_now.position, rsp_payload.position);
                  mismatch_count++;
               end
               if (rsp_payload.entry_count !== expected_now.entry_count) begin
                  $display("%0t: entry_count mismatch: expected %0d actual %0d",
                           $time, expected_now.entry_count, rsp_payload.entry_count);
                  mismatch_count++;
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            $display("%0t: rsp_valid unknown: expected 0 actual %b", $time, rsp_valid);
            mismatch_count++;
         end
      end
   end

   initial begin
      int        roll;
      int        ins_cut;
      int        find_cut;
      int        rem_cut;
      int        phase_left;
      int        pool_idx;
      phase_type phase;

      // directed: empty list, extremes, equal values, full list
      queue_item(CMD_FIND, 0);
      queue_item(CMD_REMOVE, 0);
      queue_item(CMD_INSERT, 32'h7fff_ffff);
      queue_item(CMD_INSERT, 32'h8000_0000);
      queue_item(CMD_INSERT, 0);
      queue_item(CMD_INSERT, -1);
      queue_item(CMD_INSERT, 0);
      queue_item(CMD_INSERT, 0);
      queue_item(CMD_FIND, 0);
      queue_item(CMD_FIND, 32'h7fff_ffff);
      queue_item(CMD_REMOVE, 0);
      queue_item(CMD_REMOVE, 12345);
      queue_item(CMD_UNUSED, -1);
      for (int k = 0; k < 11; k++)
         queue_item(CMD_INSERT, k * 1000 - 5000);
      // list is full here, so this one is refused
      queue_item(CMD_INSERT, 7);

      // random: phases that fill, drain or churn the list
      phase_left = 0;
      phase      = PH_MIXED;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase      = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         case (phase)
            PH_FILL:  begin ins_cut = 70; find_cut = 85; rem_cut = 98; end
            PH_DRAIN: begin ins_cut = 20; find_cut = 40; rem_cut = 98; end
            default:  begin ins_cut = 40; find_cut = 70; rem_cut = 98; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < ins_cut) begin
            queue_item(CMD_INSERT, pick_value());
         end else if (roll < find_cut) begin
            queue_item(CMD_FIND, pick_value());
         end else if (roll < rem_cut) begin
            if (recent_values.size() != 0 && $urandom_range(0, 9) < 7) begin
               pool_idx = $urandom_range(0, recent_values.size() - 1);
               queue_item(CMD_REMOVE, recent_values[pool_idx]);
               recent_values.delete(pool_idx);
            end else begin
               queue_item(CMD_REMOVE, pick_value());
            end
         end else begin
            queue_item(CMD_UNUSED, $urandom);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked; inserts placed %0d, refused on full list %0d",
               items_accepted, results_seen, hit_count[CMD_INSERT], miss_count[CMD_INSERT]);
      $display("finds hit %0d missed %0d, removes done %0d missed %0d, unused code %0d, peak fill %0d of %0d",
               hit_count[CMD_FIND], miss_count[CMD_FIND], hit_count[CMD_REMOVE],
               miss_count[CMD_REMOVE], miss_count[CMD_UNUSED], peak_count, LIST_CAP);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("** sorted_list_engine_unit: PASSED **");
      else
         $display("** sorted_list_engine_unit: FAILED **");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #200000;
      $display("timeout: %0d items still to send, %0d results outstanding",
               pending_items.size(), expected_results.size());
      $display("** sorted_list_engine_unit: FAILED **");
      $finish;
   end

endmodule
